// ===== hdl/rsa_pkg.sv =====
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the repeat site alignment score core.
// ----------------------------------------------------------------------------
package rsa_pkg;

  // Field widths
  localparam int CFG_W   = 6;    // small configuration registers
  localparam int CODE_W  = 4;    // nucleotide mask
  localparam int WORD_W  = 64;   // pattern word
  localparam int PAT_WORDS = 3;  // pattern words in the register file
  localparam int PAT_W   = PAT_WORDS * WORD_W;
  localparam int CELL_W  = 15;   // finite cell score, saturating
  localparam int COL_W   = 8;    // column arithmetic (holds sums of two registers + 1)
  localparam int BEST_W  = CELL_W + 2;  // signed end score minus row index
  localparam int SUM_W   = BEST_W + 1;  // signed best plus row index
  localparam int MAXS_W  = CELL_W + 1;  // unsigned running maximum
  localparam int SCORE_W = 11;
  localparam int IDX_W   = 3;

  localparam logic [CELL_W-1:0]  CELL_SAT  = '1;
  localparam logic [SCORE_W-1:0] SCORE_SAT = '1;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_SITE_LENGTH     = 3'd0;
  localparam logic [IDX_W-1:0] REG_REPEAT_POSITION = 3'd1;
  localparam logic [IDX_W-1:0] REG_FLANK5_MIN      = 3'd2;
  localparam logic [IDX_W-1:0] REG_FLANK3_MIN      = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_MISMATCH    = 3'd4;
  localparam logic [IDX_W-1:0] REG_PATTERN_WORD_0  = 3'd5;
  localparam logic [IDX_W-1:0] REG_PATTERN_WORD_1  = 3'd6;
  localparam logic [IDX_W-1:0] REG_PATTERN_WORD_2  = 3'd7;

  // One score cell; fin low means minus infinity
  typedef struct packed {
    logic              fin;
    logic [CELL_W-1:0] val;
  } cell_t;

  // Column configuration seen by every cell
  typedef struct packed {
    logic [CFG_W-1:0] site_n;   // clamped site length
    logic [CFG_W-1:0] rep_pos;
    logic [CFG_W-1:0] flank5;
    logic [CFG_W-1:0] flank3;
  } col_cfg_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_FINAL
  } state_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic accept;    // base transfer this cycle
    logic tmax_clr;  // last base transfer, restart tail maximum
    logic scan_en;   // tail maximum ripples one cell
    logic load;      // result goes into the output register
  } ctrl_t;

endpackage

// ===== hdl/rsa_cell.sv =====
// ----------------------------------------------------------------------------
// rsa_cell
// One pattern column: holds its score, updates it from the left neighbor on
// every base, and passes a running tail maximum to the right after a read.
// ----------------------------------------------------------------------------
module rsa_cell
  import rsa_pkg::*;
#(
  parameter int COL = 1
) (
  input  logic              clk,
  input  logic              step,
  input  logic              fresh,
  input  col_cfg_t          cfg,
  input  logic [CODE_W-1:0] pat_code,
  input  logic [CODE_W-1:0] base,
  input  cell_t             old_in,
  output cell_t             old_out,
  output cell_t             end_out,
  input  logic              tmax_clr,
  input  logic              tmax_en,
  input  logic [CELL_W-1:0] tmax_in,
  output logic [CELL_W-1:0] tmax_out
);

  localparam logic [COL_W-1:0] COL_B = COL_W'(COL);

  cell_t             score;
  cell_t             own;
  cell_t             cand;
  cell_t             nxt;
  logic              active;
  logic              start_fin;
  logic              is_rep;
  logic              is_end;
  logic              is_tail;
  logic [COL_W-1:0]  tail_lo;
  logic [CELL_W-1:0] tval;
  logic [CELL_W-1:0] tmax;

  // Column role from configuration
  always_comb begin
    tail_lo   = COL_W'(cfg.rep_pos) + COL_W'(cfg.flank3) + COL_W'(1);
    active    = COL_B <= COL_W'(cfg.site_n);
    start_fin = active && (COL_B + COL_W'(cfg.flank5) <= COL_W'(cfg.rep_pos));
    is_rep    = COL_B == COL_W'(cfg.rep_pos) + COL_W'(1);
    is_end    = COL_B == COL_W'(cfg.site_n);
    is_tail   = (COL_B >= tail_lo) && (COL_B < COL_W'(cfg.site_n));
  end

  // Previous-row value; the start row replaces it on the first base
  always_comb begin
    if (fresh) begin
      own.fin = start_fin;
      own.val = '0;
    end else begin
      own = score;
    end
  end

  // Diagonal, or stay on the repeat column when larger; then score the match
  always_comb begin
    cand = old_in;
    if (is_rep && own.fin && (!cand.fin || own.val > cand.val)) begin
      cand = own;
    end
    nxt = cand;
    if (cand.fin && ((pat_code & base) != '0) && (cand.val != CELL_SAT)) begin
      nxt.val = cand.val + CELL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      score <= active ? nxt : own;
    end
  end

  // Tail maximum ripples left to right, one cell per cycle
  assign tval = (is_tail && score.fin) ? score.val : '0;

  always_ff @(posedge clk) begin
    if (tmax_clr) begin
      tmax <= '0;
    end else if (tmax_en) begin
      tmax <= (tval > tmax_in) ? tval : tmax_in;
    end
  end

  assign old_out  = own;
  assign end_out  = is_end ? nxt : '0;
  assign tmax_out = tmax;

endmodule

// ===== hdl/rsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsa_ctrl
// Read sequencer: takes bases, runs the tail scan after the last base and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module rsa_ctrl
  import rsa_pkg::*;
#(
  parameter int SCAN_LEN = 48
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  last_base,
  input  logic  out_valid,
  input  logic  out_stall,
  output logic  in_stall,
  output ctrl_t ctrl
);

  localparam int CNT_W = $clog2(SCAN_LEN);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SCAN_LEN - 1);

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] count;
  logic             out_free;

  assign out_free = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (in_valid && last_base) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count == CNT_LAST) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall      = 1'b1;
    ctrl          = '0;
    case (state)
      ST_RUN: begin
        in_stall      = 1'b0;
        ctrl.accept   = in_valid;
        ctrl.tmax_clr = in_valid && last_base;
      end
      ST_SCAN: begin
        ctrl.scan_en = 1'b1;
      end
      ST_FINAL: begin
        ctrl.load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) begin
        count <= count + CNT_W'(1);
      end else begin
        count <= '0;
      end
    end
  end

endmodule

// ===== hdl/repeat_site_alignment_score_core.sv =====
// ----------------------------------------------------------------------------
// repeat_site_alignment_score_core
// Semi-global alignment of a read against a site pattern with a repeat base.
// ----------------------------------------------------------------------------
// Bases are taken one per clock while a read is in progress; each column of
// the score row is a cell that updates from its left neighbor in the same
// cycle. After the transfer of a base with last_base set, in_stall stays high
// while the tail-column maximum ripples through the chain of cells one cell
// per cycle, and longer if the previous result still sits unread in the
// output register. The next read may start while the result waits in the
// output register. Configuration writes take effect on the next base; the
// start row is built from the values seen at the first base of each read.
module repeat_site_alignment_score_core
  import rsa_pkg::*;
#(
  parameter int MAX_SITE_LENGTH = 48,
  parameter int MAX_READ_LENGTH = 1023
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [WORD_W-1:0]  cfg_wdata,
  // bases in
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CODE_W-1:0]  base_code,
  input  logic               last_base,
  // scores out
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SCORE_W-1:0] match_score
);

  localparam int RW = $clog2(MAX_READ_LENGTH + 1);
  localparam logic [RW-1:0]    READ_MAX = RW'(MAX_READ_LENGTH);
  localparam logic [CFG_W-1:0] SITE_MAX = CFG_W'(MAX_SITE_LENGTH);

  // Configuration registers
  logic [CFG_W-1:0] site_length;
  logic [CFG_W-1:0] repeat_position;
  logic [CFG_W-1:0] flank5_min;
  logic [CFG_W-1:0] flank3_min;
  logic [CFG_W-1:0] max_mismatch;
  logic [PAT_W-1:0] pattern;

  always_ff @(posedge clk) begin
    if (rst) begin
      site_length     <= CFG_W'(1);
      repeat_position <= '0;
      flank5_min      <= '0;
      flank3_min      <= '0;
      max_mismatch    <= '0;
      pattern         <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SITE_LENGTH:     site_length     <= cfg_wdata[CFG_W-1:0];
        REG_REPEAT_POSITION: repeat_position <= cfg_wdata[CFG_W-1:0];
        REG_FLANK5_MIN:      flank5_min      <= cfg_wdata[CFG_W-1:0];
        REG_FLANK3_MIN:      flank3_min      <= cfg_wdata[CFG_W-1:0];
        REG_MAX_MISMATCH:    max_mismatch    <= cfg_wdata[CFG_W-1:0];
        REG_PATTERN_WORD_0:  pattern[0*WORD_W +: WORD_W] <= cfg_wdata;
        REG_PATTERN_WORD_1:  pattern[1*WORD_W +: WORD_W] <= cfg_wdata;
        REG_PATTERN_WORD_2:  pattern[2*WORD_W +: WORD_W] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped site length and column configuration
  col_cfg_t cfg;

  always_comb begin
    if (site_length == '0) begin
      cfg.site_n = CFG_W'(1);
    end else if (site_length > SITE_MAX) begin
      cfg.site_n = SITE_MAX;
    end else begin
      cfg.site_n = site_length;
    end
    cfg.rep_pos = repeat_position;
    cfg.flank5  = flank5_min;
    cfg.flank3  = flank3_min;
  end

  // Sequencer
  ctrl_t ctrl;

  rsa_ctrl #(
    .SCAN_LEN (MAX_SITE_LENGTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_base (last_base),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .ctrl      (ctrl)
  );

  // Read progress
  logic          fresh;      // next base starts a new read
  logic [RW-1:0] row_index;
  logic [RW-1:0] row_next;

  always_comb begin
    if (fresh) begin
      row_next = RW'(1);
    end else if (row_index == READ_MAX) begin
      row_next = READ_MAX;
    end else begin
      row_next = row_index + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b1;
      row_index <= '0;
    end else if (ctrl.accept) begin
      fresh     <= last_base;
      row_index <= row_next;
    end
  end

  // Chain of cells; column 0 holds the row index
  cell_t             old_chain  [MAX_SITE_LENGTH+1];
  cell_t             end_vec    [MAX_SITE_LENGTH+1];
  logic [CELL_W-1:0] tmax_chain [MAX_SITE_LENGTH+1];

  always_comb begin
    if (fresh) begin
      old_chain[0].fin = flank5_min <= repeat_position;
      old_chain[0].val = '0;
    end else begin
      old_chain[0].fin = 1'b1;
      old_chain[0].val = CELL_W'(row_index);
    end
  end

  assign end_vec[0]    = '0;
  assign tmax_chain[0] = '0;

  for (genvar g = 1; g <= MAX_SITE_LENGTH; g++) begin : g_col
    rsa_cell #(
      .COL (g)
    ) u_cell (
      .clk      (clk),
      .step     (ctrl.accept),
      .fresh    (fresh),
      .cfg      (cfg),
      .pat_code (pattern[CODE_W*(g-1) +: CODE_W]),
      .base     (base_code),
      .old_in   (old_chain[g-1]),
      .old_out  (old_chain[g]),
      .end_out  (end_vec[g]),
      .tmax_clr (ctrl.tmax_clr),
      .tmax_en  (ctrl.scan_en),
      .tmax_in  (tmax_chain[g-1]),
      .tmax_out (tmax_chain[g])
    );
  end

  // End column select (one-hot OR)
  cell_t end_c;

  always_comb begin
    end_c = '0;
    for (int k = 0; k <= MAX_SITE_LENGTH; k++) begin
      end_c = cell_t'(end_c | end_vec[k]);
    end
  end

  // Best end score minus row index
  logic                     best_set;
  logic signed [BEST_W-1:0] best_val;
  logic signed [BEST_W-1:0] diff;
  logic                     base_set;

  assign diff     = $signed(BEST_W'(end_c.val)) - $signed(BEST_W'(row_next));
  assign base_set = best_set && !fresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      best_set <= 1'b0;
    end else if (ctrl.accept) begin
      if (end_c.fin && (!base_set || diff > best_val)) begin
        best_set <= 1'b1;
        best_val <= diff;
      end else begin
        best_set <= base_set;
      end
    end
  end

  // Best plus final row index, registered during the scan
  logic signed [SUM_W-1:0] sum;
  logic [MAXS_W-1:0]       msum;

  assign sum = SUM_W'(best_val) + $signed(SUM_W'(row_index));

  always_ff @(posedge clk) begin
    if (ctrl.scan_en) begin
      msum <= (best_set && sum > 0) ? MAXS_W'(sum) : '0;
    end
  end

  // Final score: tail maximum, mismatch limit, saturation
  logic [MAXS_W-1:0]  mfin;
  logic [MAXS_W:0]    allow;
  logic [SCORE_W-1:0] result;

  always_comb begin
    mfin  = (MAXS_W'(tmax_chain[MAX_SITE_LENGTH]) > msum)
            ? MAXS_W'(tmax_chain[MAX_SITE_LENGTH]) : msum;
    allow = (MAXS_W+1)'(mfin) + (MAXS_W+1)'({max_mismatch, 1'b0});
    if ((MAXS_W+1)'(cfg.site_n) > allow) begin
      result = '0;
    end else if (mfin > MAXS_W'(SCORE_SAT)) begin
      result = SCORE_SAT;
    end else begin
      result = SCORE_W'(mfin);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      match_score <= result;
    end
  end

endmodule

// ===== hdl/rsa_checker.sv =====
// ----------------------------------------------------------------------------
// rsa_checker
// Port-level checks for the repeat site alignment score core.
// ----------------------------------------------------------------------------
module rsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        last_base,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] match_score
);

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(match_score))
    else $error("result changed while stalled");

  // A base that does not end a read never blocks the next one
  a_mid_read_open: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !last_base |=> !in_stall)
    else $error("input blocked inside a read");

  // The last base starts the tail scan
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && last_base |=> in_stall)
    else $error("input open right after last base");

  // A new result only appears at the end of a scan
  a_result_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a finished scan");

endmodule

bind repeat_site_alignment_score_core rsa_checker u_rsa_checker (.*);
